// File: rtl/pcgd_pkg.sv
// Shared types, constants and helpers for the charge gate digitizer.
package pcgd_pkg;

	// Fixed field widths of the hit and digit items.
	localparam int TUBE_W   = 16;
	localparam int HTIME_W  = 32;
	localparam int CHARGE_W = 16;
	localparam int INDEX_W  = 8;
	localparam int DTIME_W  = 32;
	localparam int DCHG_W   = 24;

	// Configuration port layout.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Default structural sizes.
	localparam int TIME_BITS_DEF   = 32;
	localparam int SUM_BITS_DEF    = 24;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Gain is unsigned Q1.15.
	localparam int GAIN_FRAC = 15;
	localparam logic [DCHG_W-1:0] CHARGE_MAX = '1;
	localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

	// Register reset values.
	localparam logic [15:0] GATE_WIDTH_RST      = 16'd1600;
	localparam logic        DEADTIME_EN_RST     = 1'b0;
	localparam logic [15:0] DEADTIME_LENGTH_RST = 16'd4000;
	localparam logic [23:0] CHARGE_THRESH_RST   = 24'd0;
	localparam logic [15:0] EFF_GAIN_RST        = 16'd32276;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GATE_WIDTH      = 3'd0,
		CFG_DEADTIME_ENABLE = 3'd1,
		CFG_DEADTIME_LENGTH = 3'd2,
		CFG_CHARGE_THRESH   = 3'd3,
		CFG_EFF_GAIN        = 3'd4
	} cfg_idx_t;

	// Register file contents.
	typedef struct packed {
		logic [15:0] gate_width;
		logic        deadtime_enable;
		logic [15:0] deadtime_length;
		logic [23:0] charge_threshold;
		logic [15:0] efficiency_gain;
	} cfg_t;

	// Queue handshake between front and back.
	typedef struct packed {
		logic valid;
		logic pop;
	} queue_ctl_t;

	// Ordinal counter that sticks at its top value.
	function automatic logic [INDEX_W-1:0] sat_inc_index(input logic [INDEX_W-1:0] v);
		sat_inc_index = (v == INDEX_MAX) ? v : v + INDEX_W'(1);
	endfunction

endpackage

// File: rtl/pcgd_if.sv
// Hit and digit channel interfaces with valid/ready handshake.
interface pcgd_hit_if;
	logic                           valid;
	logic                           ready;
	logic [pcgd_pkg::TUBE_W-1:0]    tube_id;
	logic [pcgd_pkg::HTIME_W-1:0]   hit_time;
	logic [pcgd_pkg::CHARGE_W-1:0]  hit_charge;
	logic                           first_hit;
	logic                           last_hit;

	modport source(output valid, tube_id, hit_time, hit_charge, first_hit, last_hit,
		input ready);
	modport sink(input valid, tube_id, hit_time, hit_charge, first_hit, last_hit,
		output ready);
endinterface

interface pcgd_digit_if;
	logic                           valid;
	logic                           ready;
	logic [pcgd_pkg::TUBE_W-1:0]    digit_tube;
	logic [pcgd_pkg::INDEX_W-1:0]   digit_index;
	logic [pcgd_pkg::DTIME_W-1:0]   digit_time;
	logic [pcgd_pkg::DCHG_W-1:0]    digit_charge;
	logic                           last_of_run;

	modport source(output valid, digit_tube, digit_index, digit_time, digit_charge,
		last_of_run, input ready);
	modport sink(input valid, digit_tube, digit_index, digit_time, digit_charge,
		last_of_run, output ready);
endinterface

// File: rtl/pcgd_front.sv
// Front end: window tracking per hit and classification of emission attempts.
module pcgd_front #(
	parameter int TIME_BITS = pcgd_pkg::TIME_BITS_DEF,
	parameter int SUM_BITS  = pcgd_pkg::SUM_BITS_DEF,
	parameter int ENTRY_W   = pcgd_pkg::TUBE_W
		+ 2 * (1 + pcgd_pkg::INDEX_W + pcgd_pkg::DTIME_W + SUM_BITS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcgd_pkg::cfg_t       cfg,
	pcgd_hit_if.sink             hit,
	input  logic                 q_full,
	output logic                 q_push,
	output logic [ENTRY_W-1:0]   q_data
);
	import pcgd_pkg::*;

	// One queue entry: up to two attempts that passed the threshold.
	typedef struct packed {
		logic [TUBE_W-1:0]   tube;
		logic                a_v;
		logic [INDEX_W-1:0]  a_idx;
		logic [DTIME_W-1:0]  a_time;
		logic [SUM_BITS-1:0] a_sum;
		logic                b_v;
		logic [INDEX_W-1:0]  b_idx;
		logic [DTIME_W-1:0]  b_time;
		logic [SUM_BITS-1:0] b_sum;
	} entry_t;

	// Window state.
	logic [TIME_BITS-1:0] win_start_q;
	logic [TIME_BITS:0]   win_end_q;
	logic [SUM_BITS-1:0]  sum_q;
	logic                 pending_q;
	logic [INDEX_W-1:0]   digits_q;
	logic [TUBE_W-1:0]    tube_q;

	logic [63:0]          t_ext;
	logic [TIME_BITS-1:0] t;
	logic [SUM_BITS-1:0]  q_sb;
	logic [15:0]          dead;
	logic [TIME_BITS:0]   end_new;
	logic                 accept;

	logic [TIME_BITS-1:0] ws1;
	logic [TIME_BITS:0]   we1;
	logic [SUM_BITS-1:0]  sum1, sum2, sum3;
	logic [SUM_BITS:0]    sum_add;
	logic                 pend1, pend2, pend3, pend4;
	logic [INDEX_W-1:0]   dig1, dig2, dig3;
	logic [TUBE_W-1:0]    tube1;
	logic                 in_win, make, pass_a, opens, pass_b;
	logic [TIME_BITS-1:0] ws3;
	logic [TIME_BITS:0]   we3;
	logic [63:0]          ws1_ext, t_ext2;
	entry_t               ent;

	assign accept = hit.valid && hit.ready;
	assign hit.ready = !q_full;

	// Hit time and charge in internal widths.
	always_comb begin
		t_ext   = 64'(hit.hit_time);
		t       = t_ext[TIME_BITS-1:0];
		t_ext2  = 64'(t);
		q_sb    = SUM_BITS'(hit.hit_charge);
		dead    = cfg.deadtime_enable ? cfg.deadtime_length : 16'd0;
		end_new = {1'b0, t} + (TIME_BITS+1)'(cfg.gate_width);
	end

	// First hit of a tube restarts the bookkeeping.
	always_comb begin
		if (hit.first_hit) begin
			tube1 = hit.tube_id;
			ws1   = t;
			we1   = end_new;
			sum1  = '0;
			pend1 = 1'b0;
			dig1  = '0;
		end else begin
			tube1 = tube_q;
			ws1   = win_start_q;
			we1   = win_end_q;
			sum1  = sum_q;
			pend1 = pending_q;
			dig1  = digits_q;
		end
	end

	// Charge integration and the closing attempt.
	always_comb begin
		in_win  = (t >= ws1) && ({1'b0, t} <= we1);
		sum_add = {1'b0, sum1} + {1'b0, q_sb};
		if (in_win) begin
			sum2  = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
			pend2 = 1'b1;
			make  = hit.last_hit;
		end else begin
			sum2  = sum1;
			pend2 = pend1;
			make  = pend1;
		end
		pass_a = make && (64'(sum2) >= 64'(cfg.charge_threshold));
		dig2   = pass_a ? sat_inc_index(dig1) : dig1;
		pend3  = pass_a ? 1'b0 : pend2;
	end

	// A hit beyond the deadtime opens a fresh window.
	always_comb begin
		opens  = {2'b0, t} > ({1'b0, we1} + (TIME_BITS+2)'(dead));
		pass_b = opens && hit.last_hit && (64'(q_sb) >= 64'(cfg.charge_threshold));
		dig3   = pass_b ? sat_inc_index(dig2) : dig2;
		if (opens) begin
			ws3   = t;
			we3   = end_new;
			sum3  = q_sb;
			pend4 = !pass_b;
		end else begin
			ws3   = ws1;
			we3   = we1;
			sum3  = sum2;
			pend4 = pend3;
		end
	end

	// Queue entry packing.
	always_comb begin
		ws1_ext    = 64'(ws1);
		ent.tube   = tube1;
		ent.a_v    = pass_a;
		ent.a_idx  = dig1;
		ent.a_time = ws1_ext[DTIME_W-1:0];
		ent.a_sum  = sum2;
		ent.b_v    = pass_b;
		ent.b_idx  = dig2;
		ent.b_time = t_ext2[DTIME_W-1:0];
		ent.b_sum  = q_sb;
	end

	assign q_push = accept && (pass_a || pass_b);
	assign q_data = ent;

	// State update on every accepted hit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= '0;
			win_end_q   <= '0;
			sum_q       <= '0;
			pending_q   <= 1'b0;
			digits_q    <= '0;
			tube_q      <= '0;
		end else if (accept) begin
			win_start_q <= ws3;
			win_end_q   <= we3;
			sum_q       <= sum3;
			pending_q   <= pend4;
			digits_q    <= dig3;
			tube_q      <= tube1;
		end
	end

endmodule

// File: rtl/pcgd_queue.sv
// Short queue of attempt records between the front and back ends.
module pcgd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pcgd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     din,
	output logic                 full,
	output pcgd_pkg::queue_ctl_t ctl_out,
	input  logic                 pop,
	output logic [WIDTH-1:0]     dout
);
	import pcgd_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [IW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_pop;

	assign full          = (count_q == CW'(DEPTH));
	assign ctl_out.valid = (count_q != '0);
	assign ctl_out.pop   = do_pop;
	assign do_pop        = pop && (count_q != '0);
	assign dout          = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + IW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + IW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/pcgd_back.sv
// Back end: gain scaling, saturation, zero drop and digit output.
module pcgd_back #(
	parameter int SUM_BITS = pcgd_pkg::SUM_BITS_DEF,
	parameter int ENTRY_W  = pcgd_pkg::TUBE_W
		+ 2 * (1 + pcgd_pkg::INDEX_W + pcgd_pkg::DTIME_W + SUM_BITS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          efficiency_gain,
	input  pcgd_pkg::queue_ctl_t q_ctl,
	output logic                 q_pop,
	input  logic [ENTRY_W-1:0]   q_data,
	pcgd_digit_if.source         digit
);
	import pcgd_pkg::*;

	localparam int PW = SUM_BITS + 16;

	typedef struct packed {
		logic [TUBE_W-1:0]   tube;
		logic                a_v;
		logic [INDEX_W-1:0]  a_idx;
		logic [DTIME_W-1:0]  a_time;
		logic [SUM_BITS-1:0] a_sum;
		logic                b_v;
		logic [INDEX_W-1:0]  b_idx;
		logic [DTIME_W-1:0]  b_time;
		logic [SUM_BITS-1:0] b_sum;
	} entry_t;

	// Round to nearest after the Q1.15 product and clamp to the output width.
	function automatic logic [DCHG_W-1:0] scale_sat(input logic [PW-1:0] p);
		logic [PW:0]  rnd;
		logic [63:0]  sc;
		rnd = {1'b0, p} + (PW+1)'(1 << (GAIN_FRAC - 1));
		sc  = 64'(rnd[PW:GAIN_FRAC]);
		scale_sat = (sc > 64'(CHARGE_MAX)) ? CHARGE_MAX : sc[DCHG_W-1:0];
	endfunction

	entry_t           ent;
	logic [PW-1:0]    mult_a, mult_b;

	// Stage 1: products.
	logic               v_s1;
	logic [TUBE_W-1:0]  tube_s1;
	logic               a_v_s1, b_v_s1;
	logic [INDEX_W-1:0] a_idx_s1, b_idx_s1;
	logic [DTIME_W-1:0] a_time_s1, b_time_s1;
	logic [PW-1:0]      a_prod_s1, b_prod_s1;

	// Stage 2: digits waiting for transfer.
	logic               a_s2, b_s2;
	logic [TUBE_W-1:0]  tube_s2;
	logic [INDEX_W-1:0] a_idx_s2, b_idx_s2;
	logic [DTIME_W-1:0] a_time_s2, b_time_s2;
	logic [DCHG_W-1:0]  a_chg_s2, b_chg_s2;

	logic [DCHG_W-1:0]  a_chg, b_chg;
	logic               xfer, s2_free, s1_adv, s1_free, pop;

	assign ent    = q_data;
	assign mult_a = PW'(ent.a_sum) * PW'(efficiency_gain);
	assign mult_b = PW'(ent.b_sum) * PW'(efficiency_gain);
	assign a_chg  = scale_sat(a_prod_s1);
	assign b_chg  = scale_sat(b_prod_s1);

	// Flow control through the two stages.
	assign xfer    = digit.valid && digit.ready;
	assign s2_free = !(a_s2 || b_s2) || (digit.ready && !(a_s2 && b_s2));
	assign s1_adv  = v_s1 && s2_free;
	assign s1_free = !v_s1 || s1_adv;
	assign pop     = q_ctl.valid && s1_free;
	assign q_pop   = pop;

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			tube_s1   <= ent.tube;
			a_v_s1    <= ent.a_v;
			b_v_s1    <= ent.b_v;
			a_idx_s1  <= ent.a_idx;
			b_idx_s1  <= ent.b_idx;
			a_time_s1 <= ent.a_time;
			b_time_s1 <= ent.b_time;
			a_prod_s1 <= mult_a;
			b_prod_s1 <= mult_b;
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			tube_s2   <= tube_s1;
			a_idx_s2  <= a_idx_s1;
			b_idx_s2  <= b_idx_s1;
			a_time_s2 <= a_time_s1;
			b_time_s2 <= b_time_s1;
			a_chg_s2  <= a_chg;
			b_chg_s2  <= b_chg;
		end
	end

	// Occupancy: a digit with zero charge is dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			a_s2 <= 1'b0;
			b_s2 <= 1'b0;
		end else begin
			if (pop) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				a_s2 <= a_v_s1 && (a_chg != '0);
				b_s2 <= b_v_s1 && (b_chg != '0);
			end else if (xfer) begin
				if (a_s2) begin
					a_s2 <= 1'b0;
				end else begin
					b_s2 <= 1'b0;
				end
			end
		end
	end

	// Output selection: the earlier attempt goes first.
	assign digit.valid        = a_s2 || b_s2;
	assign digit.digit_tube   = tube_s2;
	assign digit.digit_index  = a_s2 ? a_idx_s2 : b_idx_s2;
	assign digit.digit_time   = a_s2 ? a_time_s2 : b_time_s2;
	assign digit.digit_charge = a_s2 ? a_chg_s2 : b_chg_s2;
	assign digit.last_of_run  = a_s2 ? !b_s2 : 1'b1;

endmodule

// File: rtl/pmt_charge_gate_digitizer.sv
// A hit's digits pass through the attempt queue, the product stage and the output stage before they are offered.
// Throughput: one hit per cycle while hit.ready is high; a hit that yields two digits offers them one after the other,
// and the four-entry attempt queue absorbs such bursts before hit.ready drops.
// The window update (compares and one saturating add) finishes in the accepting cycle.
// Reset (arst_n low) clears the window state, the queue and the output stages and
// loads the register defaults; no clearing pass is needed.
module pmt_charge_gate_digitizer #(
	parameter int TIME_BITS   = pcgd_pkg::TIME_BITS_DEF,
	parameter int SUM_BITS    = pcgd_pkg::SUM_BITS_DEF,
	parameter int QUEUE_DEPTH = pcgd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pcgd_hit_if.sink                        hit,
	pcgd_digit_if.source                    digit,
	input  logic                            cfg_we,
	input  logic [pcgd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcgd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pcgd_pkg::*;

	localparam int ENTRY_W = TUBE_W + 2 * (1 + INDEX_W + DTIME_W + SUM_BITS);

	cfg_t               cfg_q;
	logic               q_full, q_push, q_pop;
	logic [ENTRY_W-1:0] q_din, q_dout;
	queue_ctl_t         q_ctl;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_width       <= GATE_WIDTH_RST;
			cfg_q.deadtime_enable  <= DEADTIME_EN_RST;
			cfg_q.deadtime_length  <= DEADTIME_LENGTH_RST;
			cfg_q.charge_threshold <= CHARGE_THRESH_RST;
			cfg_q.efficiency_gain  <= EFF_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GATE_WIDTH:      cfg_q.gate_width       <= cfg_wdata[15:0];
				CFG_DEADTIME_ENABLE: cfg_q.deadtime_enable  <= cfg_wdata[0];
				CFG_DEADTIME_LENGTH: cfg_q.deadtime_length  <= cfg_wdata[15:0];
				CFG_CHARGE_THRESH:   cfg_q.charge_threshold <= cfg_wdata[23:0];
				CFG_EFF_GAIN:        cfg_q.efficiency_gain  <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Window tracking and attempt classification.
	pcgd_front #(
		.TIME_BITS(TIME_BITS),
		.SUM_BITS (SUM_BITS),
		.ENTRY_W  (ENTRY_W)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.hit   (hit),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_din)
	);

	// Attempt queue.
	pcgd_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.ctl_out(q_ctl),
		.pop    (q_pop),
		.dout   (q_dout)
	);

	// Scaling and digit output.
	pcgd_back #(
		.SUM_BITS(SUM_BITS),
		.ENTRY_W (ENTRY_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.efficiency_gain(cfg_q.efficiency_gain),
		.q_ctl          (q_ctl),
		.q_pop          (q_pop),
		.q_data         (q_dout),
		.digit          (digit)
	);

endmodule
